// ===== src/sle_pkg.sv =====
package sle_pkg;

   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SIZE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic insert_en;
      logic delete_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic le;
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

// ===== src/sle_cell.sv =====
module sle_cell (
   input  logic                   clock,
   input  sle_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  sle_pkg::value_type     key,
   input  logic                   left_le,
   input  sle_pkg::value_type     left_entry,
   input  sle_pkg::value_type     right_entry,
   output sle_pkg::cell_flags_type flags,
   output sle_pkg::value_type     entry
);
   import sle_pkg::*;

   value_type entry_ff;
   value_type entry_in;

   assign flags.le = occupied && (entry_ff <= key);
   assign flags.lt = occupied && (entry_ff <  key);
   assign flags.eq = occupied && (entry_ff == key);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (!flags.le) begin
            entry_in = left_le ? key : left_entry;
         end
      end else if (ctrl.delete_en) begin
         if (!flags.lt) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== src/sorted_list_engine.sv =====
// Sorted list engine: holds up to CAPACITY signed 32-bit values in ascending
// order in a row of cells. Each request beat (insert, delete first match,
// search, or size query) is resolved at once: every cell compares its entry
// against the request value and shifts toward or from its neighbor, so a new
// command is accepted every cycle while req_tready is high. The response beat
// (status and entry count after the command) appears in the cycle after
// acceptance in an output register; req_tready stays high while that
// register is empty or being drained. No clearing pass is needed after reset.
module sorted_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] command, [33:2] value, [39:34] zero
   input  logic [sle_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [8:2] entry_count, [15:9] zero
   output logic [sle_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sle_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CMD_W-1:0]     cmd;
   value_type            key;
   logic                 accept;
   logic                 list_full;
   logic                 list_empty;
   logic                 found;
   cell_ctrl_type        ctrl;
   logic [STATUS_W-1:0]  status;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic [CAPACITY-1:0]  occupied;
   logic [CAPACITY-1:0]  eq_vec;
   cell_flags_type       flags   [CAPACITY];
   value_type            entries [CAPACITY];

   assign cmd        = req_tdata[CMD_W-1:0];
   assign key        = req_tdata[CMD_W+VALUE_W-1:CMD_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign list_full  = count_ff >= CNT_W'(CAPACITY);
   assign list_empty = count_ff == '0;
   assign found      = |eq_vec;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      left_le;
      value_type left_entry;
      value_type right_entry;

      assign occupied[i] = count_ff > CNT_W'(i);
      assign eq_vec[i]   = flags[i].eq;

      if (i == 0) begin : g_first
         assign left_le    = 1'b1;
         assign left_entry = key;
      end else begin : g_mid
         assign left_le    = flags[i-1].le;
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .key         (key),
         .left_le     (left_le),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .flags       (flags[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      ctrl     = '0;
      status   = ST_DONE;
      count_in = count_ff;
      unique case (cmd)
         CMD_INSERT: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert_en = accept;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         CMD_DELETE: begin
            priority if (list_empty) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOT_FOUND;
            end else begin
               ctrl.delete_en = accept;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         CMD_SEARCH: begin
            priority if (list_empty) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOT_FOUND;
            end
         end
         CMD_SIZE: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - STATUS_W - COUNT_OUT_W)'(0),
                        COUNT_OUT_W'(rsp_count_ff), rsp_status_ff};

endmodule

// ===== src/sle_checker.sv =====
module sle_checker #(
   parameter int CAPACITY = 64
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sle_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sle_pkg::*;

   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_count  = rsp_tdata[STATUS_W+COUNT_OUT_W-1:STATUS_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response beat");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_FULL |-> rsp_count == COUNT_OUT_W'(CAPACITY))
      else $error("full status with wrong entry count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with nonzero entry count");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);
